[hdl/jbp_pkg.sv]
package jbp_pkg;

	// Saturation limits for the two length fields.
	localparam int CODE_WIDTH = 16;
	localparam int EXTRA_WIDTH = 16;

	// Fixed field widths of an input beat.
	localparam int FIELD_W = 16;
	localparam int LEN_W = 5;
	localparam int BYTE_W = 8;

	// Packed input payload, padded to whole bytes.
	localparam int IN_RAW_W = 2 * FIELD_W + 2 * LEN_W;
	localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;

	// Joined code and extra bits, and the bit buffer in the back end.
	localparam int WORD_W = CODE_WIDTH + EXTRA_WIDTH;
	localparam int TOT_W = $clog2(WORD_W + 1);
	localparam int BUF_W = WORD_W + BYTE_W;
	localparam int CNT_W = $clog2(BUF_W);

	// Results per input item are capped.
	localparam int MAX_RESULTS = 8;
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	// Queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [BYTE_W-1:0] STUFF_TRIGGER = 8'hFF;
	localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'h00;

	// Item kinds carried in tuser.
	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic kind;
		logic [WORD_W-1:0] word;   // left aligned: first bit in the MSB
		logic [TOT_W-1:0] total;
	} entry_t;

endpackage

[hdl/jpeg_bit_packer_byte_stuffing.sv]
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid, s_tready | s_tdata: code and extra bits with lengths; s_tuser: kind
// m_      | out       | m_tvalid, m_tready | m_tdata: out_byte; m_tlast: last_byte
//
// The front end takes one beat per cycle into a two-entry queue while it has room.
// The back end takes an item from the queue, then sends its output bytes one by one,
// stuffed zeros included. A flush is taken only when the output register is free.
// Reset clears the partial byte and the queue.
// Either side may stall; the output register holds a byte until it is taken.
module jpeg_bit_packer_byte_stuffing (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// s_tdata fields from bit 0 up: code_bits, code_len, extra_bits, extra_length, zero pad.
	input  logic [jbp_pkg::IN_DATA_W-1:0] s_tdata,
	// s_tuser fields from bit 0 up: kind.
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata fields from bit 0 up: out_byte.
	output logic [jbp_pkg::BYTE_W-1:0] m_tdata,
	// m_tlast: last_byte.
	output logic m_tlast
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	jbp_pkg::entry_t push_entry;
	jbp_pkg::entry_t pop_entry;

	// Classifies and aligns each input beat.
	jbp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	// Decouples intake from byte output.
	jbp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	// Packs bits into bytes and stuffs after 0xFF.
	jbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_entry  (pop_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[hdl/jbp_front.sv]
module jbp_front (
	input  logic s_tvalid,
	output logic s_tready,
	// s_tdata fields from bit 0 up: code_bits, code_len, extra_bits, extra_length, zero pad.
	input  logic [jbp_pkg::IN_DATA_W-1:0] s_tdata,
	// s_tuser fields from bit 0 up: kind.
	input  logic s_tuser,
	input  logic q_full,
	output logic q_push,
	output jbp_pkg::entry_t q_entry
);

	logic [jbp_pkg::FIELD_W-1:0] code_bits;
	logic [jbp_pkg::LEN_W-1:0] code_len;
	logic [jbp_pkg::FIELD_W-1:0] extra_bits;
	logic [jbp_pkg::LEN_W-1:0] extra_length;
	logic [jbp_pkg::TOT_W-1:0] clen;
	logic [jbp_pkg::TOT_W-1:0] elen;
	logic [jbp_pkg::WORD_W-1:0] code_mask;
	logic [jbp_pkg::WORD_W-1:0] extra_mask;
	logic [jbp_pkg::WORD_W-1:0] code_al;
	logic [jbp_pkg::WORD_W-1:0] extra_al;

	// Unpack the beat.
	assign code_bits = s_tdata[jbp_pkg::FIELD_W-1:0];
	assign code_len = s_tdata[jbp_pkg::FIELD_W +: jbp_pkg::LEN_W];
	assign extra_bits = s_tdata[jbp_pkg::FIELD_W + jbp_pkg::LEN_W +: jbp_pkg::FIELD_W];
	assign extra_length = s_tdata[2 * jbp_pkg::FIELD_W + jbp_pkg::LEN_W +: jbp_pkg::LEN_W];

	// Saturate both lengths to their limits.
	always_comb begin
		if (int'(code_len) > jbp_pkg::CODE_WIDTH) begin
			clen = jbp_pkg::TOT_W'(jbp_pkg::CODE_WIDTH);
		end else begin
			clen = jbp_pkg::TOT_W'(code_len);
		end
		if (int'(extra_length) > jbp_pkg::EXTRA_WIDTH) begin
			elen = jbp_pkg::TOT_W'(jbp_pkg::EXTRA_WIDTH);
		end else begin
			elen = jbp_pkg::TOT_W'(extra_length);
		end
	end

	// Low-bit masks for the valid code and extra bits.
	always_comb begin
		for (int i = 0; i < jbp_pkg::WORD_W; i++) begin
			code_mask[i] = (i < int'(clen));
			extra_mask[i] = (i < int'(elen));
		end
	end

	// Place the code at the top of the word and the extra bits right after it.
	assign code_al = (jbp_pkg::WORD_W'(code_bits) & code_mask)
		<< (jbp_pkg::TOT_W'(jbp_pkg::WORD_W) - clen);
	assign extra_al = (jbp_pkg::WORD_W'(extra_bits) & extra_mask)
		<< (jbp_pkg::TOT_W'(jbp_pkg::WORD_W) - clen - elen);

	// Build the queue entry; a flush carries no bits.
	always_comb begin
		q_entry.kind = s_tuser;
		if (s_tuser == jbp_pkg::KIND_FLUSH) begin
			q_entry.word = '0;
			q_entry.total = '0;
		end else begin
			q_entry.word = code_al | extra_al;
			q_entry.total = clen + elen;
		end
	end

	assign s_tready = !q_full;
	assign q_push = s_tvalid && !q_full;

endmodule

[hdl/jbp_fifo.sv]
module jbp_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  jbp_pkg::entry_t push_entry,
	output logic full,
	input  logic pop,
	output jbp_pkg::entry_t pop_entry,
	output logic empty
);

	jbp_pkg::entry_t mem_q [jbp_pkg::Q_DEPTH];
	logic [jbp_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [jbp_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [jbp_pkg::Q_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == jbp_pkg::Q_CNT_W'(jbp_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_entry = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == jbp_pkg::Q_PTR_W'(jbp_pkg::Q_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == jbp_pkg::Q_PTR_W'(jbp_pkg::Q_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/jbp_back.sv]
module jbp_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  jbp_pkg::entry_t q_entry,
	output logic q_pop,
	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata fields from bit 0 up: out_byte.
	output logic [jbp_pkg::BYTE_W-1:0] m_tdata,
	// m_tlast: last_byte.
	output logic m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EMIT  = 3'b010,
		ST_STUFF = 3'b100
	} state_t;

	state_t state_q;
	logic [jbp_pkg::BUF_W-1:0] buf_q;
	logic [jbp_pkg::CNT_W-1:0] cnt_q;
	logic [jbp_pkg::RES_W-1:0] nres_q;
	logic m_tvalid_q;
	logic [jbp_pkg::BYTE_W-1:0] byte_q;
	logic last_q;

	logic out_free;
	logic capped;
	logic cnt_ge8;
	logic cnt_ge16;
	logic cap_last;
	logic load_beat;
	logic [jbp_pkg::BYTE_W-1:0] top_byte;
	logic [jbp_pkg::BUF_W-1:0] load_word;
	logic [jbp_pkg::CNT_W-1:0] load_cnt;

	assign out_free = !m_tvalid_q || m_tready;
	assign capped = (nres_q == jbp_pkg::RES_W'(jbp_pkg::MAX_RESULTS));
	assign cap_last = (nres_q == jbp_pkg::RES_W'(jbp_pkg::MAX_RESULTS - 1));
	assign cnt_ge8 = (cnt_q >= jbp_pkg::CNT_W'(jbp_pkg::BYTE_W));
	assign cnt_ge16 = (cnt_q >= jbp_pkg::CNT_W'(2 * jbp_pkg::BYTE_W));
	assign top_byte = buf_q[jbp_pkg::BUF_W-1 -: jbp_pkg::BYTE_W];

	// New bits land right behind the pending partial byte.
	assign load_word = {q_entry.word, {jbp_pkg::BYTE_W{1'b0}}} >> cnt_q;
	assign load_cnt = cnt_q + jbp_pkg::CNT_W'(q_entry.total);

	// A flush needs the output slot; an append only loads the buffer.
	always_comb begin
		q_pop = 1'b0;
		if (state_q == ST_IDLE && !q_empty) begin
			q_pop = (q_entry.kind == jbp_pkg::KIND_APPEND) || out_free;
		end
	end

	// A new beat enters the output register in this cycle.
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				load_beat = q_pop && (q_entry.kind == jbp_pkg::KIND_FLUSH) && (cnt_q != '0);
			end
			ST_EMIT: begin
				load_beat = cnt_ge8 && out_free && !capped;
			end
			ST_STUFF: begin
				load_beat = out_free && !capped;
			end
			default: begin
				load_beat = 1'b0;
			end
		endcase
	end

	// Byte sequencer: loads items into the buffer, drains whole bytes from it and inserts stuffing; a flush clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			buf_q <= '0;
			cnt_q <= '0;
			nres_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load_beat) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						nres_q <= '0;
						if (q_entry.kind == jbp_pkg::KIND_FLUSH) begin
							buf_q <= '0;
							cnt_q <= '0;
						end else begin
							buf_q <= buf_q | load_word;
							cnt_q <= load_cnt;
							if (load_cnt >= jbp_pkg::CNT_W'(jbp_pkg::BYTE_W)) begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_EMIT: begin
					if (!cnt_ge8) begin
						state_q <= ST_IDLE;
					end else if (capped || out_free) begin
						if (!capped) begin
							nres_q <= nres_q + 1'b1;
						end
						buf_q <= buf_q << jbp_pkg::BYTE_W;
						cnt_q <= cnt_q - jbp_pkg::CNT_W'(jbp_pkg::BYTE_W);
						if (top_byte == jbp_pkg::STUFF_TRIGGER) begin
							state_q <= ST_STUFF;
						end else if (!cnt_ge16) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STUFF: begin
					if (capped || out_free) begin
						if (!capped) begin
							nres_q <= nres_q + 1'b1;
						end
						state_q <= cnt_ge8 ? ST_EMIT : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload; loaded with each new valid beat, and also on a flush with no pending bits.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop && q_entry.kind == jbp_pkg::KIND_FLUSH) begin
					byte_q <= top_byte;
					last_q <= 1'b1;
				end
			end
			ST_EMIT: begin
				if (cnt_ge8 && out_free && !capped) begin
					byte_q <= top_byte;
					last_q <= cap_last
						|| (top_byte != jbp_pkg::STUFF_TRIGGER && !cnt_ge16);
				end
			end
			ST_STUFF: begin
				if (out_free && !capped) begin
					byte_q <= jbp_pkg::STUFF_BYTE;
					last_q <= cap_last || !cnt_ge8;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = byte_q;
	assign m_tlast = last_q;

endmodule

[verif/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One byte of the entropy-coded stream as it should leave the block.
	typedef struct packed {
		logic [jbp_pkg::BYTE_W-1:0] data;
		logic last;
	} stream_byte_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [jbp_pkg::IN_DATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [jbp_pkg::BYTE_W-1:0] m_tdata;
	logic m_tlast;

	// Bytes still owed by the block, oldest first.
	stream_byte_t expected_bytes[$];

	// Our own copy of the partial byte.
	logic [jbp_pkg::BYTE_W-1:0] partial_byte;
	int partial_count;

	int mismatches;
	int codes_sent;
	int flushes_sent;
	int bytes_checked;
	int stuffed_zeros;

	// Flow control knobs shared by the stimulus and the receiver.
	bit tx_steady;
	bit rx_steady;
	int hold_request;
	bit hold_active;

	jpeg_bit_packer_byte_stuffing i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Shift one item into the partial byte and queue every byte it completes; a flush queues the partial byte, if any.
	task automatic pack_code_bits(input logic kind, input logic [15:0] code,
			input logic [4:0] code_len, input logic [15:0] extra,
			input logic [4:0] extra_len);
		stream_byte_t produced[$];
		stream_byte_t b;
		logic [31:0] joined;
		int clen;
		int elen;
		int total;
		if (kind == jbp_pkg::KIND_FLUSH) begin
			if (partial_count > 0) begin
				b.data = partial_byte;
				b.last = 1'b0;
				produced.push_back(b);
			end
			partial_byte = '0;
			partial_count = 0;
		end else begin
			clen = (code_len > jbp_pkg::CODE_WIDTH) ? jbp_pkg::CODE_WIDTH : code_len;
			elen = (extra_len > jbp_pkg::EXTRA_WIDTH) ? jbp_pkg::EXTRA_WIDTH : extra_len;
			joined = ((32'(code) & ((32'h1 << clen) - 1)) << elen)
				| (32'(extra) & ((32'h1 << elen) - 1));
			total = clen + elen;
			for (int i = total - 1; i >= 0; i--) begin
				partial_byte[7 - partial_count] = joined[i];
				partial_count++;
				if (partial_count == 8) begin
					b.data = partial_byte;
					b.last = 1'b0;
					produced.push_back(b);
					// A completed 0xFF is always followed by a stuffed zero.
					if (partial_byte == jbp_pkg::STUFF_TRIGGER) begin
						b.data = jbp_pkg::STUFF_BYTE;
						produced.push_back(b);
						stuffed_zeros++;
					end
					partial_byte = '0;
					partial_count = 0;
				end
			end
		end
		if (produced.size() > 0)
			produced[produced.size() - 1].last = 1'b1;
		foreach (produced[i])
			expected_bytes.push_back(produced[i]);
	endtask

	// Offer one beat, wait until it is taken, then predict its bytes.
	task automatic send_item(input logic kind, input logic [15:0] code,
			input logic [4:0] code_len, input logic [15:0] extra,
			input logic [4:0] extra_len);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(jbp_pkg::IN_DATA_W - jbp_pkg::IN_RAW_W){1'b0}}, extra_len, extra,
			code_len, code};
		do @(posedge clk); while (!s_tready);
		if (kind == jbp_pkg::KIND_FLUSH)
			flushes_sent++;
		else
			codes_sent++;
		pack_code_bits(kind, code, code_len, extra, extra_len);
	endtask

	task automatic send_code(input logic [15:0] code, input logic [4:0] code_len,
			input logic [15:0] extra, input logic [4:0] extra_len);
		send_item(jbp_pkg::KIND_APPEND, code, code_len, extra, extra_len);
	endtask

	task automatic send_flush();
		send_item(jbp_pkg::KIND_FLUSH, 16'($urandom), 5'($urandom), 16'($urandom),
			5'($urandom));
	endtask

	// Stop offering beats and let every owed byte come out.
	task automatic drain_stream();
		s_tvalid <= 1'b0;
		wait (expected_bytes.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// Random append or flush, lengths mostly in range and sometimes above it.
	task automatic send_random_item();
		int r;
		logic [4:0] clen;
		logic [4:0] elen;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send_flush();
		end else begin
			clen = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(0, 16));
			elen = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
				: 5'($urandom_range(0, 16));
			send_code(16'($urandom), clen, 16'($urandom), elen);
		end
	endtask

	// Field extremes, saturation, empty items and stuffing.
	task automatic test_directed();
		send_flush();
		send_code(16'hFFFF, 5'd0, 16'hFFFF, 5'd0);
		send_code(16'hFFFF, 5'd16, 16'hFFFF, 5'd16);
		send_code(16'h0005, 5'd3, 16'h0000, 5'd0);
		send_flush();
		send_code(16'hFFFF, 5'd31, 16'h1234, 5'd0);
		send_code(16'h0000, 5'd0, 16'hA5A5, 5'd31);
		send_code(16'h5555, 5'd17, 16'hAAAA, 5'd17);
		send_code(16'h007F, 5'd7, 16'h0000, 5'd0);
		send_flush();
		send_code(16'hFFFF, 5'd4, 16'h0000, 5'd0);
		send_code(16'h0000, 5'd0, 16'hFFFF, 5'd4);
		send_code(16'h0000, 5'd16, 16'h0000, 5'd16);
		send_code(16'hFFFF, 5'd5, 16'hFFFF, 5'd2);
		send_code(16'hFFFF, 5'd1, 16'h0000, 5'd0);
		send_code(16'h0002, 5'd2, 16'h0000, 5'd0);
		send_flush();
		send_flush();
		send_code(16'h8001, 5'd16, 16'h7FFE, 5'd15);
		drain_stream();
	endtask

	task automatic test_random();
		repeat (65) send_random_item();
		drain_stream();
	endtask

	// The receiver stops for a long stretch while beats keep coming.
	task automatic test_output_hold();
		hold_request = 300;
		wait (hold_active);
		tx_steady = 1'b1;
		repeat (12) send_code(16'($urandom), 5'd16, 16'($urandom), 5'd16);
		tx_steady = 1'b0;
		drain_stream();
	endtask

	// Two bursts with a full drain in between.
	task automatic test_pause();
		repeat (4) send_random_item();
		drain_stream();
		repeat (4) send_random_item();
		drain_stream();
	endtask

	// Both sides run without gaps.
	task automatic test_back_to_back();
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (15) send_random_item();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		drain_stream();
	endtask

	// Receiver: random stalls, plus a long hold-off when asked for.
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				hold_active = 1'b1;
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
				hold_active = 1'b0;
			end else begin
				n = rx_steady ? 0 : pick_gap();
				if (n > 0) begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Compare every byte taken from the block with the oldest prediction.
	always @(posedge clk) begin
		stream_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				if (mismatches < 10)
					$display("[%0t] unexpected byte 0x%02h last=%0b", $realtime, m_tdata,
						m_tlast);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last) begin
					if (mismatches < 10)
						$display("[%0t] byte mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
							$realtime, want.data, want.last, m_tdata, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#(5_000_000);
		$display("Timeout with %0d bytes still expected.", expected_bytes.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = jbp_pkg::KIND_APPEND;
		s_tdata = '0;
		partial_byte = '0;
		partial_count = 0;
		mismatches = 0;
		codes_sent = 0;
		flushes_sent = 0;
		bytes_checked = 0;
		stuffed_zeros = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_request = 0;
		hold_active = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_output_hold();
		test_pause();
		test_back_to_back();

		wait (expected_bytes.size() == 0);
		repeat (50) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			$display("%0d expected bytes never arrived.", expected_bytes.size());
			mismatches++;
		end
		$display("Sent %0d code beats and %0d flushes; checked %0d bytes, %0d stuffed zeros.",
			codes_sent, flushes_sent, bytes_checked, stuffed_zeros);
		$display("Mismatches: %0d.", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
hdl/jbp_pkg.sv
hdl/jbp_front.sv
hdl/jbp_fifo.sv
hdl/jbp_back.sv
hdl/jpeg_bit_packer_byte_stuffing.sv
verif/tb.sv
